[sv/ppph_pkg.sv]
// Shared types and constants for the parallel port printer handshake block.
// No dependencies; every other file of the block uses this package.
package ppph_pkg;

    localparam int DELAY_W = 10;
    localparam int BYTE_W  = 8;
    localparam int OP_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W = 2;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_STROBE = 3'd1;
    localparam logic [OP_W-1:0] OP_DATA   = 3'd2;
    localparam logic [OP_W-1:0] OP_INIT   = 3'd3;
    localparam logic [OP_W-1:0] OP_ONLINE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ACK_DELAY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_WIDTH     = 2'd2;

    localparam logic [DELAY_W-1:0] ACK_DELAY_RST     = 10'd10;
    localparam logic [DELAY_W-1:0] RELEASE_DELAY_RST = 10'd7;
    localparam logic [DELAY_W-1:0] ACK_WIDTH_RST     = 10'd5;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ACK_LOW  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RELEASE  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_ACK_HIGH = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              line_level;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [DELAY_W-1:0] ack_delay_ticks;
        logic [DELAY_W-1:0] release_delay_ticks;
        logic [DELAY_W-1:0] ack_width_ticks;
    } cfg_t;

    typedef struct packed {
        logic              busy_res;
        logic              ack_level;
        logic              paper_error;
        logic              print_valid;
        logic [BYTE_W-1:0] print_byte;
    } result_t;

endpackage

[sv/ppph_cfg_regs.sv]
// Delay configuration registers of the printer handshake block.
// Depends on ppph_pkg.
module ppph_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [ppph_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [ppph_pkg::DELAY_W-1:0]     wr_data,
    output ppph_pkg::cfg_t                   cfg
);

    ppph_pkg::cfg_t cfg_reg;
    ppph_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                ppph_pkg::REG_ACK_DELAY:     cfg_next.ack_delay_ticks     = wr_data;
                ppph_pkg::REG_RELEASE_DELAY: cfg_next.release_delay_ticks = wr_data;
                ppph_pkg::REG_ACK_WIDTH:     cfg_next.ack_width_ticks     = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_delay_ticks     <= ppph_pkg::ACK_DELAY_RST;
            cfg_reg.release_delay_ticks <= ppph_pkg::RELEASE_DELAY_RST;
            cfg_reg.ack_width_ticks     <= ppph_pkg::ACK_WIDTH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/ppph_core.sv]
// Handshake state and the one-step update applied to each item.
// Depends on ppph_pkg; the state advances only when an item leaves the input register.
module ppph_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  ppph_pkg::item_t     item,
    input  ppph_pkg::cfg_t      cfg,
    output ppph_pkg::result_t   result
);

    logic                              strobe_prev_reg, strobe_prev_next;
    logic                              busy_reg, busy_next;
    logic                              ack_reg, ack_next;
    logic                              perror_reg, perror_next;
    logic [ppph_pkg::BYTE_W-1:0]       latched_reg, latched_next;
    logic [ppph_pkg::PHASE_W-1:0]      phase_reg, phase_next;
    logic [ppph_pkg::DELAY_W-1:0]      count_reg, count_next;
    logic                              print_valid;

    always_comb begin
        strobe_prev_next = strobe_prev_reg;
        busy_next        = busy_reg;
        ack_next         = ack_reg;
        perror_next      = perror_reg;
        latched_next     = latched_reg;
        phase_next       = phase_reg;
        count_next       = count_reg;
        print_valid      = 1'b0;
        case (item.op)
            ppph_pkg::OP_TICK: begin
                if (phase_reg != ppph_pkg::PH_IDLE) begin
                    if (count_reg > ppph_pkg::DELAY_W'(1)) begin
                        count_next = count_reg - ppph_pkg::DELAY_W'(1);
                    end else if (phase_reg == ppph_pkg::PH_ACK_LOW) begin
                        ack_next    = 1'b0;
                        print_valid = 1'b1;
                        phase_next  = ppph_pkg::PH_RELEASE;
                        count_next  = cfg.release_delay_ticks;
                    end else if (phase_reg == ppph_pkg::PH_RELEASE) begin
                        busy_next  = 1'b0;
                        phase_next = ppph_pkg::PH_ACK_HIGH;
                        count_next = cfg.ack_width_ticks;
                    end else begin
                        ack_next   = 1'b1;
                        phase_next = ppph_pkg::PH_IDLE;
                        count_next = '0;
                    end
                end
            end
            ppph_pkg::OP_STROBE: begin
                if (strobe_prev_reg && !item.line_level && !busy_reg) begin
                    busy_next  = 1'b1;
                    phase_next = ppph_pkg::PH_ACK_LOW;
                    count_next = cfg.ack_delay_ticks;
                end
                strobe_prev_next = item.line_level;
            end
            ppph_pkg::OP_DATA: begin
                latched_next = item.data_byte;
            end
            ppph_pkg::OP_INIT: begin
                if (!item.line_level) begin
                    busy_next = 1'b0;
                    ack_next  = 1'b1;
                end
            end
            ppph_pkg::OP_ONLINE: begin
                perror_next = ~item.line_level;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strobe_prev_reg <= 1'b0;
            busy_reg        <= 1'b0;
            ack_reg         <= 1'b1;
            perror_reg      <= 1'b0;
            latched_reg     <= '0;
            phase_reg       <= ppph_pkg::PH_IDLE;
            count_reg       <= '0;
        end else if (advance) begin
            strobe_prev_reg <= strobe_prev_next;
            busy_reg        <= busy_next;
            ack_reg         <= ack_next;
            perror_reg      <= perror_next;
            latched_reg     <= latched_next;
            phase_reg       <= phase_next;
            count_reg       <= count_next;
        end
    end

    always_comb begin
        result.busy_res    = busy_next;
        result.ack_level   = ack_next;
        result.paper_error = perror_next;
        result.print_valid = print_valid;
        result.print_byte  = print_valid ? latched_reg : '0;
    end

endmodule

[sv/parallel_port_printer_handshake_top.sv]
// Top level of the parallel port printer handshake receiver.
// Depends on ppph_pkg, ppph_cfg_regs and ppph_core.
//
//   Channel   Direction  Handshake             Payload
//   s_        in         s_valid / s_ready     s_op, s_line_level, s_data_byte
//   m_        out        m_valid / m_ready     m_busy_res, m_ack_level, m_paper_error,
//                                              m_print_valid, m_print_byte
//   cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle is accepted while m_ready does not hold the result; an item passes
// through the input register and then the result register around the step logic to m_valid.
// Reset is synchronous and active low; no item is taken while it is applied.
// A stalled result holds in the result register while one more item waits in the input register.
// Configuration writes are always taken; cfg_ready is tied high.
module parallel_port_printer_handshake_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ppph_pkg::OP_W-1:0]         s_op,
    input  logic                              s_line_level,
    input  logic [ppph_pkg::BYTE_W-1:0]       s_data_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_busy_res,
    output logic                              m_ack_level,
    output logic                              m_paper_error,
    output logic                              m_print_valid,
    output logic [ppph_pkg::BYTE_W-1:0]       m_print_byte,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppph_pkg::DELAY_W-1:0]      cfg_data
);

    logic                 in_valid_reg;
    ppph_pkg::item_t      in_item_reg;
    logic                 out_valid_reg;
    ppph_pkg::result_t    out_res_reg;
    ppph_pkg::result_t    step_res;
    ppph_pkg::cfg_t       cfg;
    logic                 advance;
    logic                 take;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = aresetn && (!in_valid_reg || advance);
    assign take      = s_valid && s_ready;

    ppph_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ppph_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_item_reg.op         <= s_op;
            in_item_reg.line_level <= s_line_level;
            in_item_reg.data_byte  <= s_data_byte;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_busy_res    = out_res_reg.busy_res;
    assign m_ack_level   = out_res_reg.ack_level;
    assign m_paper_error = out_res_reg.paper_error;
    assign m_print_valid = out_res_reg.print_valid;
    assign m_print_byte  = out_res_reg.print_byte;

endmodule

[sv/ppph_checker.sv]
// Port-level checks for the parallel port printer handshake top level.
// Depends on ppph_pkg; bound to parallel_port_printer_handshake_top below.
module ppph_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_busy_res,
    input logic                         m_ack_level,
    input logic                         m_paper_error,
    input logic                         m_print_valid,
    input logic [ppph_pkg::BYTE_W-1:0]  m_print_byte
);

    // A byte is handed over only on the step that drives ack low.
    a_print_ack_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_print_valid |-> !m_ack_level)
        else $error("print item without ack low");

    // An item that hands over no byte carries a zero byte.
    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_print_valid |-> m_print_byte == '0)
        else $error("nonzero byte without print");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_busy_res) && $stable(m_ack_level)
            && $stable(m_paper_error) && $stable(m_print_valid) && $stable(m_print_byte))
        else $error("stalled result changed");

    // Reset empties the block and takes no item.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_reset_no_take: assert property (@(posedge aclk)
        !aresetn |-> !s_ready)
        else $error("input ready during reset");

endmodule

bind parallel_port_printer_handshake_top ppph_checker u_ppph_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_busy_res    (m_busy_res),
    .m_ack_level   (m_ack_level),
    .m_paper_error (m_paper_error),
    .m_print_valid (m_print_valid),
    .m_print_byte  (m_print_byte)
);
